### rtl/core/nmi_pkg.sv
// shared types, constants and the sine table function of the downconverter
package nmi_pkg;

  localparam int unsigned TableDepthDefault = 2048;
  localparam int unsigned StateWidthDefault = 32;

  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned OUT_W       = 32;
  localparam int unsigned STEP_W      = 11;
  localparam int unsigned SHIFT_W     = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned XW          = SAMPLE_W + 1;
  localparam int unsigned ROM_W       = 16;
  localparam int unsigned MIX_W       = XW + ROM_W + 1;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN   = SHIFT_W'(3);
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = SHIFT_W'(9);
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(9);
  localparam logic signed [XW-1:0] SAMPLE_OFFSET = XW'(127);

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
  localparam int unsigned TAYLOR_TERMS = 20;
  localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420,
    64'd506, 64'd600, 64'd702, 64'd812, 64'd930, 64'd1056, 64'd1190, 64'd1332, 64'd1482,
    64'd1640
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP   = 2'd0,
    REG_FILTER_SHIFT = 2'd1,
    REG_TABLE_SIZE   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [STEP_W-1:0]  phase_step;
    logic [SHIFT_W-1:0] filter_shift;
    logic               table_size_select;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_i;
    logic [SAMPLE_W-1:0] sample_q;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered_re;
    logic signed [OUT_W-1:0] filtered_im;
  } out_item_t;

  // one entry of the sine table: 32767.5*sin(2*pi*j/2^aw), taylor series in q30
  function automatic logic [ROM_W-1:0] sine_entry(input int unsigned j, input int unsigned aw);
    logic [63:0]        quarter;
    logic [63:0]        r;
    logic [63:0]        m;
    logic [1:0]         q;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        mag;
    logic               done;
    quarter = 64'd1 << (aw - 2);
    q       = 2'((64'(j) >> (aw - 2)) & 64'd3);
    r       = 64'(j) & (quarter - 64'd1);
    m       = q[0] ? (quarter - r) : r;
    x       = (TWO_PI_Q30 * m) >> aw;
    x2      = (x * x) >> 30;
    term    = x;
    sum     = $signed(x);
    done    = 1'b0;
    for (int i = 0; i < TAYLOR_TERMS; i++) begin
      if (!done) begin
        if (term == 64'd0) begin
          done = 1'b1;
        end else begin
          term = ((term * x2) >> 30) / TAYLOR_DIV[i];
          if ((i % 2) == 0) begin
            sum = sum - $signed(term);
          end else begin
            sum = sum + $signed(term);
          end
        end
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    if ($unsigned(sum) > Q30_ONE) begin
      sum = $signed(Q30_ONE);
    end
    mag = ($unsigned(sum) * 64'd65535) >> 31;
    return q[1] ? ROM_W'(64'd0 - mag) : ROM_W'(mag);
  endfunction

endpackage

### rtl/core/nmi_fifo.sv
// small register queue used between front and back and on the result side
module nmi_fifo #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = nmi_pkg::QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d;
  logic [AW-1:0]    rptr_q, rptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign empty_o = (count_q == CW'(0));
  assign full_o  = (count_q == CW'(DEPTH));
  assign count_o = count_q;
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? AW'(0) : wptr_q + AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? AW'(0) : rptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

### rtl/core/nmi_sine_rom.sv
// two-port sine rom with registered read data
module nmi_sine_rom #(
  parameter int unsigned DEPTH = nmi_pkg::TableDepthDefault
) (
  input  logic                           clk_i,
  input  logic                           rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]       sin_addr_i,
  input  logic [$clog2(DEPTH)-1:0]       cos_addr_i,
  output logic signed [nmi_pkg::ROM_W-1:0] sin_o,
  output logic signed [nmi_pkg::ROM_W-1:0] cos_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [nmi_pkg::ROM_W-1:0] rom_mem [DEPTH];

  for (genvar j = 0; j < DEPTH; j++) begin : g_rom
    assign rom_mem[j] = nmi_pkg::sine_entry(j, AW);
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      sin_o <= $signed(rom_mem[sin_addr_i]);
      cos_o <= $signed(rom_mem[cos_addr_i]);
    end
  end

endmodule

### rtl/core/nmi_front.sv
// front end: removes the sample offset and steps the oscillator phase
module nmi_front #(
  parameter int unsigned DEPTH = nmi_pkg::TableDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nmi_pkg::cfg_t                 cfg_i,
  input  logic                          accept_i,
  input  nmi_pkg::in_item_t             item_i,
  output logic signed [nmi_pkg::XW-1:0] xr_o,
  output logic signed [nmi_pkg::XW-1:0] xi_o,
  output logic [$clog2(DEPTH)-1:0]      sin_addr_o,
  output logic [$clog2(DEPTH)-1:0]      cos_addr_o
);

  localparam int unsigned PW = $clog2(DEPTH);

  logic [PW-1:0] phase_q, phase_d;
  logic [PW-1:0] mask;
  logic [PW-1:0] quarter;
  logic [PW-1:0] p;
  logic [PW-1:0] pc;
  logic [PW-1:0] step;

  assign xr_o = $signed({1'b0, item_i.sample_i}) - nmi_pkg::SAMPLE_OFFSET;
  assign xi_o = $signed({1'b0, item_i.sample_q}) - nmi_pkg::SAMPLE_OFFSET;

  // half-period mode drops the top phase bit and reads the rom at twice the phase
  assign mask    = cfg_i.table_size_select ? {1'b0, {(PW-1){1'b1}}} : {PW{1'b1}};
  assign quarter = cfg_i.table_size_select ? PW'(DEPTH / 8) : PW'(DEPTH / 4);
  assign step    = PW'(cfg_i.phase_step);
  assign p       = phase_q & mask;
  assign pc      = (p + quarter) & mask;
  assign phase_d = (p + step) & mask;

  assign sin_addr_o = cfg_i.table_size_select ? {p[PW-2:0], 1'b0} : p;
  assign cos_addr_o = cfg_i.table_size_select ? {pc[PW-2:0], 1'b0} : pc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
    end
  end

endmodule

### rtl/core/nmi_back.sv
// back end: rom read, complex mix, two resonant low-pass rails, result queue
module nmi_back #(
  parameter int unsigned DEPTH = nmi_pkg::TableDepthDefault,
  parameter int unsigned SW    = nmi_pkg::StateWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nmi_pkg::cfg_t                 cfg_i,
  input  logic                          mid_empty_i,
  input  logic signed [nmi_pkg::XW-1:0] xr_i,
  input  logic signed [nmi_pkg::XW-1:0] xi_i,
  input  logic [$clog2(DEPTH)-1:0]      sin_addr_i,
  input  logic [$clog2(DEPTH)-1:0]      cos_addr_i,
  output logic                          mid_pop_o,
  output nmi_pkg::out_item_t            out_data_o,
  output logic                          empty_o,
  input  logic                          pop_i
);

  localparam int unsigned OD = nmi_pkg::QUEUE_DEPTH;
  localparam int unsigned CW = $clog2(OD + 1);
  localparam int unsigned XW = nmi_pkg::XW;
  localparam int unsigned MW = nmi_pkg::MIX_W;
  localparam int unsigned KW = nmi_pkg::SHIFT_W;

  logic                          v1_q, v2_q;
  logic signed [XW-1:0]          xr1_q, xi1_q;
  logic signed [nmi_pkg::ROM_W-1:0] ds, dc;
  logic signed [MW-1:0]          mr_q, mi_q;
  logic signed [MW-1:0]          mr_d, mi_d;

  logic signed [SW-1:0] re_a_q, re_b_q, re_c_q;
  logic signed [SW-1:0] im_a_q, im_b_q, im_c_q;
  logic signed [SW-1:0] re_a_d, re_b_d, re_c_d;
  logic signed [SW-1:0] im_a_d, im_b_d, im_c_d;
  logic signed [SW-1:0] re_mix, im_mix;
  logic signed [SW-1:0] re_t1, re_t2, re_t3;
  logic signed [SW-1:0] im_t1, im_t2, im_t3;

  logic [KW-1:0]      k;
  logic [KW-1:0]      km1;
  logic [CW-1:0]      out_count;
  logic [CW:0]        occupancy;
  logic               out_full;
  nmi_pkg::out_item_t out_wdata;

  // only pull from the middle queue when the result queue can take every item in flight
  assign occupancy = (CW+1)'(out_count) + (CW+1)'(v1_q) + (CW+1)'(v2_q);
  assign mid_pop_o = !mid_empty_i && (occupancy < (CW+1)'(OD));

  nmi_sine_rom #(
    .DEPTH (DEPTH)
  ) u_rom (
    .clk_i      (clk_i),
    .rd_en_i    (mid_pop_o),
    .sin_addr_i (sin_addr_i),
    .cos_addr_i (cos_addr_i),
    .sin_o      (ds),
    .cos_o      (dc)
  );

  assign mr_d = MW'(xr1_q * ds) - MW'(xi1_q * dc);
  assign mi_d = MW'(xr1_q * dc) + MW'(xi1_q * ds);

  always_comb begin
    if (cfg_i.filter_shift < nmi_pkg::SHIFT_MIN) begin
      k = nmi_pkg::SHIFT_MIN;
    end else if (cfg_i.filter_shift > nmi_pkg::SHIFT_MAX) begin
      k = nmi_pkg::SHIFT_MAX;
    end else begin
      k = cfg_i.filter_shift;
    end
  end
  assign km1 = k - KW'(1);

  assign re_mix = SW'(mr_q);
  assign im_mix = SW'(mi_q);

  // resonant low-pass, third update uses the fresh first and second states
  assign re_t1  = re_mix - re_a_q - re_c_q;
  assign re_a_d = re_a_q + (re_t1 >>> k);
  assign re_t2  = re_c_q - re_b_q;
  assign re_b_d = re_b_q + (re_t2 >>> k);
  assign re_t3  = re_a_d - re_b_d;
  assign re_c_d = re_c_q + (re_t3 >>> km1);

  assign im_t1  = im_mix - im_a_q - im_c_q;
  assign im_a_d = im_a_q + (im_t1 >>> k);
  assign im_t2  = im_c_q - im_b_q;
  assign im_b_d = im_b_q + (im_t2 >>> k);
  assign im_t3  = im_a_d - im_b_d;
  assign im_c_d = im_c_q + (im_t3 >>> km1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      re_a_q <= '0;
      re_b_q <= '0;
      re_c_q <= '0;
      im_a_q <= '0;
      im_b_q <= '0;
      im_c_q <= '0;
    end else begin
      v1_q <= mid_pop_o;
      v2_q <= v1_q;
      if (v2_q) begin
        re_a_q <= re_a_d;
        re_b_q <= re_b_d;
        re_c_q <= re_c_d;
        im_a_q <= im_a_d;
        im_b_q <= im_b_d;
        im_c_q <= im_c_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_pop_o) begin
      xr1_q <= xr_i;
      xi1_q <= xi_i;
    end
    if (v1_q) begin
      mr_q <= mr_d;
      mi_q <= mi_d;
    end
  end

  assign out_wdata.filtered_re = nmi_pkg::OUT_W'(re_b_d);
  assign out_wdata.filtered_im = nmi_pkg::OUT_W'(im_b_d);

  nmi_fifo #(
    .WIDTH ($bits(nmi_pkg::out_item_t)),
    .DEPTH (OD)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (v2_q),
    .wdata_i (out_wdata),
    .pop_i   (pop_i),
    .rdata_o (out_data_o),
    .empty_o (empty_o),
    .full_o  (out_full),
    .count_o (out_count)
  );

  a_no_result_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> !out_full)
    else $error("filter result pushed into a full result queue");

  a_occupancy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupancy <= (CW+1)'(OD))
    else $error("items in flight exceed result queue space");

  a_pipe_follows_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop_o |=> v1_q ##1 v2_q)
    else $error("popped request lost in the mix pipeline");

endmodule

### rtl/core/nco_mixer_iir_lowpass.sv
// top level: nco downconverter with integer resonant low-pass on i and q
//
//  channel   direction  handshake            payload
//  input     in         push / full          in_data_i  (sample_i, sample_q)
//  result    out        empty / pop          out_data_o (filtered_re, filtered_im)
//  config    in         cfg_we_i, cfg_idx_i  cfg_wdata_i
//
// one request per cycle sustained while the result side keeps popping; a result shows
// once its request has passed the middle queue, rom read, mix multiply and filter update
// into the result queue. the filter's three-update recurrence is registered once per request.
// reset clears the queues, the oscillator phase and all filter states; the sine rom
// is fixed and needs no clearing pass. a stalled result side backs up into the
// four-entry middle queue before full rises.
module nco_mixer_iir_lowpass #(
  parameter int unsigned TABLE_DEPTH = nmi_pkg::TableDepthDefault,
  parameter int unsigned STATE_WIDTH = nmi_pkg::StateWidthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  nmi_pkg::in_item_t                 in_data_i,
  output logic                              empty,
  input  logic                              pop,
  output nmi_pkg::out_item_t                out_data_o,
  input  logic                              cfg_we_i,
  input  logic [nmi_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [nmi_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned PW = $clog2(TABLE_DEPTH);
  localparam int unsigned XW = nmi_pkg::XW;
  localparam int unsigned MID_W = 2 * XW + 2 * PW;

  nmi_pkg::cfg_t        cfg_q;
  logic                 accept;
  logic signed [XW-1:0] f_xr, f_xi;
  logic [PW-1:0]        f_sin, f_cos;
  logic [MID_W-1:0]     mid_wdata, mid_rdata;
  logic                 mid_empty;
  logic                 mid_pop;
  logic signed [XW-1:0] b_xr, b_xi;
  logic [PW-1:0]        b_sin, b_cos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_step        <= '0;
      cfg_q.filter_shift      <= nmi_pkg::SHIFT_RESET;
      cfg_q.table_size_select <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (nmi_pkg::cfg_reg_e'(cfg_idx_i))
        nmi_pkg::REG_PHASE_STEP:   cfg_q.phase_step <= cfg_wdata_i[nmi_pkg::STEP_W-1:0];
        nmi_pkg::REG_FILTER_SHIFT: cfg_q.filter_shift <= cfg_wdata_i[nmi_pkg::SHIFT_W-1:0];
        nmi_pkg::REG_TABLE_SIZE:   cfg_q.table_size_select <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  nmi_front #(
    .DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .xr_o       (f_xr),
    .xi_o       (f_xi),
    .sin_addr_o (f_sin),
    .cos_addr_o (f_cos)
  );

  assign mid_wdata = {f_xr, f_xi, f_sin, f_cos};

  nmi_fifo #(
    .WIDTH (MID_W),
    .DEPTH (nmi_pkg::QUEUE_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i (mid_wdata),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty),
    .full_o  (full),
    .count_o ()
  );

  assign {b_xr, b_xi, b_sin, b_cos} = mid_rdata;

  nmi_back #(
    .DEPTH (TABLE_DEPTH),
    .SW    (STATE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mid_empty_i (mid_empty),
    .xr_i        (b_xr),
    .xi_i        (b_xi),
    .sin_addr_i  (b_sin),
    .cos_addr_i  (b_cos),
    .mid_pop_o   (mid_pop),
    .out_data_o  (out_data_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

### verif/nco_mixer_iir_lowpass_tb.sv
// self-checking testbench for the nco downconverter with resonant iir low-pass
module nco_mixer_iir_lowpass_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RomDepth = 2048;
  localparam logic [63:0] TwoPiQ30 = 64'd6746518852;
  localparam int unsigned Phases = 8;
  localparam int unsigned PhaseSamples = 50;

  // predicts the filtered i/q for every accepted request and checks results in order
  class ddc_scoreboard;
    logic signed [15:0]     sine_lut [RomDepth];
    logic [10:0]            osc_phase;
    logic [10:0]            phase_step;
    logic [3:0]             shift_k;
    logic                   half_period;
    logic [31:0]            re_s1, re_s2, re_s3;
    logic [31:0]            im_s1, im_s2, im_s3;
    nmi_pkg::out_item_t     expected_q [$];
    int                     errors;
    int                     compared;
    int                     accepted;

    function new();
      int unsigned quarter;
      int unsigned qd;
      int unsigned r;
      logic [63:0] mag;
      quarter = RomDepth / 4;
      for (int unsigned j = 0; j < RomDepth; j++) begin
        qd  = j / quarter;
        r   = j % quarter;
        mag = (quarter_sine_q30(qd[0] ? quarter - r : r) * 64'd65535) >> 31;
        sine_lut[j] = qd[1] ? -16'(mag) : 16'(mag);
      end
      osc_phase   = '0;
      phase_step  = '0;
      shift_k     = 4'd9;
      half_period = 1'b0;
      re_s1 = '0; re_s2 = '0; re_s3 = '0;
      im_s1 = '0; im_s2 = '0; im_s3 = '0;
      errors   = 0;
      compared = 0;
      accepted = 0;
    endfunction

    // sin(2*pi*m/depth) in q30 over the first quadrant, taylor series
    function logic [63:0] quarter_sine_q30(int unsigned m);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] acc;
      int unsigned        n;
      bit                 neg;
      x    = (TwoPiQ30 * 64'(m)) / RomDepth;
      x2   = (x * x) >> 30;
      term = x;
      acc  = $signed(x);
      n    = 1;
      neg  = 1'b1;
      while (term != 0 && n < 40) begin
        term = ((term * x2) >> 30) / 64'((n + 1) * (n + 2));
        n += 2;
        if (neg) acc = acc - $signed(term);
        else acc = acc + $signed(term);
        neg = !neg;
      end
      if (acc < 0) acc = 0;
      if ($unsigned(acc) > (64'd1 << 30)) acc = 64'sd1 <<< 30;
      return $unsigned(acc);
    endfunction

    function logic [31:0] asr32(logic [31:0] v, int k);
      return $signed(v) >>> k;
    endfunction

    function void lowpass(input logic [31:0] mix, input int k,
                          inout logic [31:0] a, inout logic [31:0] b, inout logic [31:0] c);
      a = a + asr32(mix - a - c, k);
      b = b + asr32(c - b, k);
      c = c + asr32(a - b, k - 1);
    endfunction

    function void write_reg(nmi_pkg::cfg_reg_e idx, logic [nmi_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        nmi_pkg::REG_PHASE_STEP:   phase_step  = val[10:0];
        nmi_pkg::REG_FILTER_SHIFT: shift_k     = val[3:0];
        nmi_pkg::REG_TABLE_SIZE:   half_period = val[0];
        default: ;
      endcase
    endfunction

    function void take_sample(nmi_pkg::in_item_t s);
      int                 xr;
      int                 xi;
      int                 ds;
      int                 dc;
      int                 k;
      int unsigned        per;
      int unsigned        p;
      int unsigned        pc;
      longint             mr;
      longint             mi;
      nmi_pkg::out_item_t res;
      xr = int'(s.sample_i) - 127;
      xi = int'(s.sample_q) - 127;
      k  = int'(shift_k);
      if (k < 3) k = 3;
      if (k > 9) k = 9;
      // phase is masked to the current period before use
      per = half_period ? RomDepth / 2 : RomDepth;
      p   = int'(osc_phase) & (per - 1);
      pc  = (p + per / 4) & (per - 1);
      if (half_period) begin
        ds = sine_lut[(p * 2) & (RomDepth - 1)];
        dc = sine_lut[(pc * 2) & (RomDepth - 1)];
      end else begin
        ds = sine_lut[p];
        dc = sine_lut[pc];
      end
      osc_phase = 11'((p + int'(phase_step)) & (per - 1));
      mr = longint'(xr) * ds - longint'(xi) * dc;
      mi = longint'(xr) * dc + longint'(xi) * ds;
      lowpass(mr[31:0], k, re_s1, re_s2, re_s3);
      lowpass(mi[31:0], k, im_s1, im_s2, im_s3);
      res.filtered_re = re_s2;
      res.filtered_im = im_s2;
      expected_q.push_back(res);
      accepted++;
    endfunction

    function void compare_output(nmi_pkg::out_item_t got);
      nmi_pkg::out_item_t exp_item;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: re %0d im %0d",
               got.filtered_re, got.filtered_im);
        errors++;
        return;
      end
      exp_item = expected_q.pop_front();
      compared++;
      if (got.filtered_re !== exp_item.filtered_re) begin
        $error("filtered_re: expected %0d, got %0d", exp_item.filtered_re, got.filtered_re);
        errors++;
      end
      if (got.filtered_im !== exp_item.filtered_im) begin
        $error("filtered_im: expected %0d, got %0d", exp_item.filtered_im, got.filtered_im);
        errors++;
      end
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           push;
  logic                           full;
  nmi_pkg::in_item_t              in_data;
  logic                           empty;
  logic                           pop;
  nmi_pkg::out_item_t             out_data;
  logic                           cfg_we;
  logic [nmi_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [nmi_pkg::CFG_DATA_W-1:0] cfg_wdata;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int          settings_run;
  ddc_scoreboard sb = new();

  nco_mixer_iir_lowpass u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: check on every pop, then roll the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.compare_output(out_data);
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_sample(input nmi_pkg::in_item_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      push    <= 1'b0;
      in_data <= nmi_pkg::in_item_t'($urandom);
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_data <= s;
    do @(posedge clk_i); while (full);
    sb.take_sample(s);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // all three registers, write enable held high across the burst
  task automatic write_config(input logic [10:0] step,
                              input logic [nmi_pkg::CFG_DATA_W-1:0] shift_word,
                              input logic [nmi_pkg::CFG_DATA_W-1:0] mode_word);
    cfg_we    <= 1'b1;
    cfg_idx   <= nmi_pkg::REG_PHASE_STEP;
    cfg_wdata <= step;
    @(posedge clk_i);
    cfg_idx   <= nmi_pkg::REG_FILTER_SHIFT;
    cfg_wdata <= shift_word;
    @(posedge clk_i);
    cfg_idx   <= nmi_pkg::REG_TABLE_SIZE;
    cfg_wdata <= mode_word;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.write_reg(nmi_pkg::REG_PHASE_STEP, step);
    sb.write_reg(nmi_pkg::REG_FILTER_SHIFT, shift_word);
    sb.write_reg(nmi_pkg::REG_TABLE_SIZE, mode_word);
    settings_run++;
  endtask

  task automatic send_pair(input logic [7:0] si, input logic [7:0] sq);
    nmi_pkg::in_item_t s;
    s.sample_i = si;
    s.sample_q = sq;
    send_sample(s);
  endtask

  initial begin
    nmi_pkg::in_item_t cur;
    logic [10:0]       step;
    logic [3:0]        shift;
    logic              mode;
    int unsigned       roll;
    push           = 1'b0;
    in_data        = '0;
    pop            = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = nmi_pkg::REG_PHASE_STEP;
    cfg_wdata      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    settings_run   = 1;
    rst_ni         = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, field extremes and the zero point
    send_pair(8'd0, 8'd0);
    send_pair(8'd255, 8'd255);
    send_pair(8'd0, 8'd255);
    send_pair(8'd255, 8'd0);
    send_pair(8'd127, 8'd127);
    send_pair(8'd128, 8'd128);
    wait_drained();

    // shift below the legal range, largest step
    write_config(11'd2047, nmi_pkg::CFG_DATA_W'(0), nmi_pkg::CFG_DATA_W'(0));
    send_pair(8'd255, 8'd0);
    send_pair(8'd0, 8'd255);
    send_pair(8'd255, 8'd255);
    send_pair(8'd0, 8'd0);
    send_pair(8'd200, 8'd50);
    wait_drained();

    // half period with the phase left above it, shift above the legal range
    write_config(11'd2047, nmi_pkg::CFG_DATA_W'(15), nmi_pkg::CFG_DATA_W'(1));
    send_pair(8'd255, 8'd255);
    send_pair(8'd0, 8'd0);
    send_pair(8'd255, 8'd0);
    send_pair(8'd1, 8'd254);
    send_pair(8'd128, 8'd126);
    wait_drained();

    // unused upper bits of the write data must be ignored
    write_config(11'd513, {7'h55, 4'd2}, {10'h2aa, 1'b1});
    send_pair(8'd0, 8'd255);
    send_pair(8'd255, 8'd0);
    send_pair(8'd0, 8'd0);
    send_pair(8'd255, 8'd255);
    send_pair(8'd170, 8'd85);
    wait_drained();

    cur = '0;
    for (int ph = 0; ph < Phases; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      step  = (ph == 0) ? 11'd2047 : (ph == 1) ? 11'd0 : (ph == 2) ? 11'd1
              : 11'($urandom_range(2047));
      shift = (ph == 0) ? 4'd3 : (ph == 1) ? 4'd9 : 4'($urandom_range(15));
      mode  = ph[0] ^ ph[2];
      write_config(step, {7'($urandom_range(127)), shift}, {10'($urandom_range(1023)), mode});
      for (int n = 0; n < PhaseSamples; n++) begin
        roll = $urandom_range(99);
        // bursts of held samples push the filter toward large states
        if (roll < 25) begin
        end else if (roll < 35) begin
          cur.sample_i = $urandom_range(1) ? 8'd255 : 8'd0;
          cur.sample_q = $urandom_range(1) ? 8'd255 : 8'd0;
        end else begin
          cur = nmi_pkg::in_item_t'($urandom);
        end
        send_sample(cur);
      end
      wait_drained();
    end

    $display("%0d requests sent over %0d register settings, %0d results compared",
             sb.accepted, settings_run, sb.compared);
    $display("shift clamping, both table periods and all idle patterns exercised");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", sb.expected_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
